>>> rtl/status_led_animation_generator_defines.svh
// ---------------------------------------------------------------------------
// Status LED animation generator - assertion macros
// Clocked, reset-qualified property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_ANIMATION_GENERATOR_DEFINES_SVH
`define STATUS_LED_ANIMATION_GENERATOR_DEFINES_SVH

// same-cycle implication
`define SLAG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slag checker: same-cycle property failed");

// next-cycle implication
`define SLAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slag checker: next-cycle property failed");

`endif

>>> rtl/slag_pkg.sv
// ---------------------------------------------------------------------------
// slag_pkg
// Shared types, status table and reciprocal constants for the status LED
// animation generator.
// ---------------------------------------------------------------------------
`default_nettype none

package slag_pkg;

  localparam int unsigned PEAK_LEVEL = 32;
  localparam int unsigned CONNECT_GREEN = 20;
  localparam int unsigned FULL_FACTOR = 255;

  typedef logic [2:0] status_t;

  localparam status_t ST_OFFLINE    = 3'd0;
  localparam status_t ST_CONNECTING = 3'd1;
  localparam status_t ST_WAITING    = 3'd2;
  localparam status_t ST_WORKING    = 3'd3;
  localparam status_t ST_YOLO       = 3'd4;

  typedef struct packed {
    logic    valid;
    status_t status;
  } stage_ctl_t;

  // now / period: floor reciprocal, quotient may be one low
  localparam int unsigned RECIP_SHIFT = 41;
  // x*255 / half: ceil reciprocal, exact for x*255 < 2^18
  localparam int unsigned HALF_SHIFT  = 40;
  // p / 255: ceil reciprocal, exact for p < 2^13
  localparam int unsigned SCALE_SHIFT = 24;

  localparam logic [31:0] RECIP_600  = 32'((64'd1 << RECIP_SHIFT) / 600);
  localparam logic [31:0] RECIP_800  = 32'((64'd1 << RECIP_SHIFT) / 800);
  localparam logic [31:0] RECIP_1000 = 32'((64'd1 << RECIP_SHIFT) / 1000);
  localparam logic [31:0] RECIP_2000 = 32'((64'd1 << RECIP_SHIFT) / 2000);

  localparam logic [31:0] HRECIP_300  = 32'(((64'd1 << HALF_SHIFT) + 299) / 300);
  localparam logic [31:0] HRECIP_400  = 32'(((64'd1 << HALF_SHIFT) + 399) / 400);
  localparam logic [31:0] HRECIP_500  = 32'(((64'd1 << HALF_SHIFT) + 499) / 500);
  localparam logic [31:0] HRECIP_1000 = 32'(((64'd1 << HALF_SHIFT) + 999) / 1000);

  localparam logic [31:0] SCALE_RECIP =
    32'(((64'd1 << SCALE_SHIFT) + FULL_FACTOR - 1) / FULL_FACTOR);

  function automatic logic [10:0] period_of(status_t s);
    logic [10:0] p;
    case (s)
      ST_CONNECTING: p = 11'd800;
      ST_WAITING:    p = 11'd2000;
      ST_YOLO:       p = 11'd1000;
      default:       p = 11'd600;
    endcase
    return p;
  endfunction

  function automatic logic [9:0] half_of(status_t s);
    logic [9:0] h;
    case (s)
      ST_CONNECTING: h = 10'd400;
      ST_WAITING:    h = 10'd1000;
      ST_YOLO:       h = 10'd500;
      default:       h = 10'd300;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] recip_of(status_t s);
    logic [31:0] r;
    case (s)
      ST_CONNECTING: r = RECIP_800;
      ST_WAITING:    r = RECIP_2000;
      ST_YOLO:       r = RECIP_1000;
      default:       r = RECIP_600;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] half_recip_of(status_t s);
    logic [31:0] r;
    case (s)
      ST_CONNECTING: r = HRECIP_400;
      ST_WAITING:    r = HRECIP_1000;
      ST_YOLO:       r = HRECIP_500;
      default:       r = HRECIP_300;
    endcase
    return r;
  endfunction

  function automatic logic is_blink(status_t s);
    return (s == ST_OFFLINE);
  endfunction

  function automatic logic [7:0] red_of(status_t s);
    logic [7:0] c;
    case (s)
      ST_OFFLINE, ST_CONNECTING, ST_YOLO: c = 8'(PEAK_LEVEL);
      default:                            c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] green_of(status_t s);
    logic [7:0] c;
    case (s)
      ST_CONNECTING: c = 8'(CONNECT_GREEN);
      ST_WAITING:    c = 8'(PEAK_LEVEL);
      default:       c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blue_of(status_t s);
    logic [7:0] c;
    case (s)
      ST_WORKING, ST_YOLO: c = 8'(PEAK_LEVEL);
      default:             c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/slag_phase.sv
// ---------------------------------------------------------------------------
// slag_phase
// Three-stage modulo unit: phase = now_ms mod period by reciprocal multiply,
// back-multiply and one correcting subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module slag_phase (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire slag_pkg::stage_ctl_t ctl_in,
  input  wire logic [31:0]        now_in,
  output slag_pkg::stage_ctl_t    ctl_out,
  output logic [10:0]             phase_out
);

  slag_pkg::stage_ctl_t ctl_a_r, ctl_b_r, ctl_c_r;
  logic [22:0] quot_a_r;
  logic [11:0] now_a_r;
  logic [11:0] back_b_r;
  logic [11:0] now_b_r;
  logic [10:0] phase_c_r;

  logic [63:0] quot_prod;
  logic [31:0] back_prod;
  logic [11:0] diff;
  logic [11:0] period_w;
  logic [11:0] phase_nxt;

  always_comb begin
    quot_prod = 64'(now_in) * 64'(slag_pkg::recip_of(ctl_in.status));
    back_prod = 32'(quot_a_r) * 32'(slag_pkg::period_of(ctl_a_r.status));
    // true remainder is below twice the period, so 12 bits wrap cleanly
    diff      = now_b_r - back_b_r;
    period_w  = 12'(slag_pkg::period_of(ctl_b_r.status));
    phase_nxt = (diff >= period_w) ? (diff - period_w) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_in;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_a_r  <= quot_prod[63:slag_pkg::RECIP_SHIFT];
      now_a_r   <= now_in[11:0];
      back_b_r  <= back_prod[11:0];
      now_b_r   <= now_a_r;
      phase_c_r <= phase_nxt[10:0];
    end
  end

  assign ctl_out   = ctl_c_r;
  assign phase_out = phase_c_r;

endmodule

`default_nettype wire

>>> rtl/status_led_animation_generator.sv
// ---------------------------------------------------------------------------
// status_led_animation_generator
// Per tick word, one GRB colour triple from the configured status and time.
//
//   channel | ports                         | direction
//   in      | in_valid/in_stall, in_now_ms  | tick word in
//   out     | out_valid/out_stall, levels   | GRB word out
//   cfg     | APB psel..pready              | status_select at offset 0
//
// Eight register stages; one word accepted per cycle while no out word is held.
// Depth set by the modulo unit (three multiply/correct stages), the factor
// divide and the /255 scale multiply.
// A held out word freezes the whole pipeline; in_stall follows it.
// Synchronous active-low reset clears valids and status_select (offline).
// ---------------------------------------------------------------------------
`default_nettype none

module status_led_animation_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_green_level,
  output logic [7:0]       out_red_level,
  output logic [7:0]       out_blue_level,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic en;

  slag_pkg::status_t status_r;

  slag_pkg::stage_ctl_t ctl1_r, ctl4, ctl5_r, ctl6_r, ctl7_r;
  logic [31:0] now1_r;
  logic [10:0] phase4;
  logic [17:0] num5_r;
  logic        below5_r;
  logic [7:0]  factor6_r;
  logic [12:0] red7_r, green7_r, blue7_r;
  logic        out_valid_r;
  logic [7:0]  green_r, red_r, blue_r;

  slag_pkg::status_t status_eff;
  logic [9:0]  half4;
  logic        below4;
  logic [9:0]  x4;
  logic [49:0] fprod;
  logic [7:0]  factor_nxt;
  logic [15:0] red_p, green_p, blue_p;
  logic [31:0] red_s, green_s, blue_s;

  // config
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= slag_pkg::ST_OFFLINE;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      status_r <= pwdata[2:0];
    end
  end

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign status_eff = (status_r > slag_pkg::ST_YOLO) ? slag_pkg::ST_OFFLINE : status_r;

  // stage 1: capture tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= '{valid: in_valid, status: status_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      now1_r <= in_now_ms;
    end
  end

  // stages 2 to 4: phase
  slag_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (ctl1_r),
    .now_in    (now1_r),
    .ctl_out   (ctl4),
    .phase_out (phase4)
  );

  always_comb begin
    half4  = slag_pkg::half_of(ctl4.status);
    below4 = (phase4 < 11'(half4));
    x4     = below4 ? phase4[9:0] : 10'(slag_pkg::period_of(ctl4.status) - phase4);
    fprod  = 50'(num5_r) * 50'(slag_pkg::half_recip_of(ctl5_r.status));
    if (slag_pkg::is_blink(ctl5_r.status)) begin
      factor_nxt = below5_r ? 8'(slag_pkg::FULL_FACTOR) : 8'd0;
    end else begin
      factor_nxt = fprod[slag_pkg::HALF_SHIFT +: 8];
    end
    red_p   = 16'(slag_pkg::red_of(ctl6_r.status))   * 16'(factor6_r);
    green_p = 16'(slag_pkg::green_of(ctl6_r.status)) * 16'(factor6_r);
    blue_p  = 16'(slag_pkg::blue_of(ctl6_r.status))  * 16'(factor6_r);
    red_s   = 32'(red7_r)   * slag_pkg::SCALE_RECIP;
    green_s = 32'(green7_r) * slag_pkg::SCALE_RECIP;
    blue_s  = 32'(blue7_r)  * slag_pkg::SCALE_RECIP;
  end

  // stages 5 to 8
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r      <= '0;
      ctl6_r      <= '0;
      ctl7_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl5_r      <= ctl4;
      ctl6_r      <= ctl5_r;
      ctl7_r      <= ctl6_r;
      out_valid_r <= ctl7_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5_r    <= 18'({x4, 8'd0}) - 18'(x4);
      below5_r  <= below4;
      factor6_r <= factor_nxt;
      red7_r    <= red_p[12:0];
      green7_r  <= green_p[12:0];
      blue7_r   <= blue_p[12:0];
      red_r     <= red_s[31:slag_pkg::SCALE_SHIFT];
      green_r   <= green_s[31:slag_pkg::SCALE_SHIFT];
      blue_r    <= blue_s[31:slag_pkg::SCALE_SHIFT];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_green_level = green_r;
  assign out_red_level   = red_r;
  assign out_blue_level  = blue_r;

endmodule

`default_nettype wire

>>> rtl/slag_checker.sv
// ---------------------------------------------------------------------------
// slag_checker
// Port-level checks on the status LED animation generator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "status_led_animation_generator_defines.svh"

module slag_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_green_level,
  input wire logic [7:0]  out_red_level,
  input wire logic [7:0]  out_blue_level,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // held word stays put
  `SLAG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({out_green_level, out_red_level, out_blue_level}))

  // input only backs up behind a held output word
  `SLAG_ASSERT_IMPL(a_in_stall_cause, in_stall, out_valid && out_stall)

  // no channel exceeds the peak level
  `SLAG_ASSERT_IMPL(a_level_peak, out_valid, (out_red_level <= 8'(slag_pkg::PEAK_LEVEL)) && (out_green_level <= 8'(slag_pkg::PEAK_LEVEL)) && (out_blue_level <= 8'(slag_pkg::PEAK_LEVEL)))

  // status readback only ever carries three bits
  `SLAG_ASSERT_IMPL(a_prdata_width, pready, prdata[31:3] == 29'd0)

endmodule

bind status_led_animation_generator slag_checker u_slag_checker (.*);

`default_nettype wire
